[src/lbqs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbqs_pkg
// Shared types, constants and key helpers of the log-bucket quantile sketch.
// ----------------------------------------------------------------------------
package lbqs_pkg;

  localparam int MAX_BINS   = 64;
  localparam int KEY_BITS   = 16;
  localparam int COUNT_BITS = 32;
  localparam int DEPTH      = MAX_BINS + 1;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int ENT_BITS   = KEY_BITS + COUNT_BITS;
  localparam int SUM_BITS   = COUNT_BITS + ADDR_BITS;

  localparam logic [KEY_BITS:0]     KEY_MAX = (KEY_BITS + 1)'((1 << (KEY_BITS - 1)) - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [4:0]            LEVEL_MAX = 5'd31;
  localparam logic [16:0]           Q_ONE = 17'd65536;

  // operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_INV_GAMMA = 2'd0;
  localparam logic [1:0] REG_OFFSET    = 2'd1;
  localparam logic [1:0] REG_BIN_LIMIT = 2'd2;

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [COUNT_BITS-1:0]      cnt_t;

  // magnitude of a stored key with the offset taken off
  function automatic logic [KEY_BITS:0] mag_of(key_t k, logic [10:0] off);
    logic [KEY_BITS:0] a;
    a = k[KEY_BITS-1] ? (KEY_BITS + 1)'(-$signed({k[KEY_BITS-1], k})) : {1'b0, k};
    if (a < (KEY_BITS + 1)'(off)) return '0;
    return a - (KEY_BITS + 1)'(off);
  endfunction

  // signed key from a magnitude, offset added and clamped
  function automatic key_t make_key(logic neg, logic [31:0] mag, logic [10:0] off);
    logic [32:0] t;
    t = {1'b0, mag} + 33'(off);
    if (t > 33'(KEY_MAX)) t = 33'(KEY_MAX);
    return neg ? key_t'(-t[KEY_BITS-1:0]) : key_t'(t[KEY_BITS-1:0]);
  endfunction

  function automatic key_t halve_key(key_t k, logic [10:0] off);
    logic [31:0] m;
    m = 32'(mag_of(k, off)) + 32'd1;
    if (k == '0) return '0;
    return make_key(k[KEY_BITS-1], m >> 1, off);
  endfunction

  function automatic key_t plain_key(key_t k, logic [10:0] off);
    logic [KEY_BITS:0] m;
    m = mag_of(k, off);
    if (k == '0) return '0;
    return k[KEY_BITS-1] ? key_t'(-m[KEY_BITS-1:0]) : key_t'(m[KEY_BITS-1:0]);
  endfunction

  function automatic cnt_t cnt_inc(cnt_t c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic cnt_t cnt_add(cnt_t a, cnt_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  // sequencer states
  typedef enum logic [26:0] {
    ST_IDLE   = 27'b000000000000000000000000001,
    ST_NORM   = 27'b000000000000000000000000010,
    ST_SQ     = 27'b000000000000000000000000100,
    ST_SQCHK  = 27'b000000000000000000000001000,
    ST_LGMUL  = 27'b000000000000000000000010000,
    ST_KEY    = 27'b000000000000000000000100000,
    ST_FRD    = 27'b000000000000000000001000000,
    ST_FCMP   = 27'b000000000000000000010000000,
    ST_UPD    = 27'b000000000000000000100000000,
    ST_SHRD   = 27'b000000000000000001000000000,
    ST_SHWR   = 27'b000000000000000010000000000,
    ST_FULL   = 27'b000000000000000100000000000,
    ST_DSRD   = 27'b000000000000001000000000000,
    ST_DSWR   = 27'b000000000000010000000000000,
    ST_COLTST = 27'b000000000000100000000000000,
    ST_COLRD  = 27'b000000000001000000000000000,
    ST_COLCHK = 27'b000000000010000000000000000,
    ST_CMPRD  = 27'b000000000100000000000000000,
    ST_CMPWR  = 27'b000000001000000000000000000,
    ST_QMUL   = 27'b000000010000000000000000000,
    ST_QMUL2  = 27'b000000100000000000000000000,
    ST_QT     = 27'b000001000000000000000000000,
    ST_QRD    = 27'b000010000000000000000000000,
    ST_QACC   = 27'b000100000000000000000000000,
    ST_DONE   = 27'b001000000000000000000000000,
    ST_SPARE1 = 27'b010000000000000000000000000,
    ST_SPARE2 = 27'b100000000000000000000000000
  } state_t;

endpackage

[src/lbqs_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbqs_in_if
// Request channel of the sketch: operation, sample and quantile.
// ----------------------------------------------------------------------------
interface lbqs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic signed [31:0] sample;
  logic [16:0] quantile_q;
  modport source (output valid, func, sample, quantile_q, input ready);
  modport sink (input valid, func, sample, quantile_q, output ready);
endinterface

[src/lbqs_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbqs_out_if
// Result channel of the sketch.
// ----------------------------------------------------------------------------
interface lbqs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [15:0] bucket_key;
  logic [31:0] bucket_count;
  logic [4:0]  collapse_level;
  logic [6:0]  buckets_used;
  logic [31:0] total_count;
  modport source (output valid, status, bucket_key, bucket_count, collapse_level,
                  buckets_used, total_count, input ready);
  modport sink (input valid, status, bucket_key, bucket_count, collapse_level,
                buckets_used, total_count, output ready);
endinterface

[src/lbqs_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbqs_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lbqs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/lbqs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

[src/log_bucket_quantile_sketch.sv]
`timescale 1ns / 1ps
// Sequence: insert/delete first form the key (normalising shifts of one bit, 16 squarings
//   on the shared multiplier, then the scale multiply and rounding), then search the
//   table, shift it and run any collapse passes; a query multiplies, then walks the
//   buckets.
// Throughput: one request at a time; the next is taken once the sequencer is idle.
// Reset: synchronous active-low rst_n clears sequencer, counters, output valid and loads
//   config defaults; the table is not cleared, only entries below the bucket count are used.
// ----------------------------------------------------------------------------
// log_bucket_quantile_sketch
// Log-bucket quantile sketch with a sorted bucket table in RAM, run by a sequencer
// around one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module log_bucket_quantile_sketch
  import lbqs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  lbqs_in_if.sink      in_ch,
  lbqs_out_if.source   out_ch,
  lbqs_cfg_if.sink     cfg_ch
);

  state_t state_r, state_nxt;

  // configuration
  logic [31:0] inv_gamma_r;
  logic [10:0] key_offset_r;
  logic [6:0]  bin_limit_r;

  // sketch state
  logic [ADDR_BITS-1:0] used_r;
  logic [4:0]           level_r;
  cnt_t                 total_r;

  // request and work registers
  logic [1:0]  func_r;
  logic [16:0] q_r;
  logic        neg_r;
  logic [31:0] y_r;
  logic [4:0]  e_r;
  logic [20:0] lg_r;
  logic [3:0]  bit_r;
  key_t        key_r;
  logic [ADDR_BITS-1:0] idx_r, pos_r, w_r;
  logic        found_r, final_r, changed_r, have_acc_r, zero_r;
  cnt_t        ent_cnt_r;
  key_t        acc_key_r;
  cnt_t        acc_cnt_r;
  logic [31:0] t_r;
  logic [SUM_BITS-1:0] sum_r;
  logic [1:0]  res_status_r;
  key_t        res_key_r;
  cnt_t        res_cnt_r;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r;

  // table RAM
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr, rd_addr;
  logic [ENT_BITS-1:0]  wr_data, rd_data;
  key_t                 rd_key;
  cnt_t                 rd_cnt;

  // combinational helpers
  logic [6:0]  limit;
  logic [32:0] sq;
  logic [5:0]  sh;
  logic [63:0] shq;
  logic        shrem;
  logic [31:0] tot_m1;
  logic [SUM_BITS-1:0] qsum;
  key_t        nk;

  assign rd_key = key_t'(rd_data[ENT_BITS-1:COUNT_BITS]);
  assign rd_cnt = rd_data[COUNT_BITS-1:0];
  assign limit  = (bin_limit_r > 7'(MAX_BINS)) ? 7'(MAX_BINS) : bin_limit_r;
  assign sq     = prod_r[63:31];
  assign sh     = 6'd32 + 6'(level_r);
  assign shq    = prod_r >> sh;
  assign shrem  = |(prod_r & ~({64{1'b1}} << sh));
  assign tot_m1 = total_r - 32'd1;
  assign qsum   = (idx_r == '0) ? SUM_BITS'(rd_cnt) : sum_r + SUM_BITS'(rd_cnt);
  assign nk     = halve_key(rd_key, key_offset_r);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  lbqs_ram #(.WIDTH(ENT_BITS), .DEPTH(DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // multiplier operands, ram ports and next state
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    wr_en     = 1'b0;
    wr_addr   = pos_r;
    wr_data   = '0;
    rd_addr   = idx_r;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.func)
            FUNC_INSERT, FUNC_DELETE: begin
              state_nxt = (in_ch.sample == '0) ? ST_FRD : ST_NORM;
            end
            FUNC_QUERY: begin
              if (used_r == '0) state_nxt = ST_DONE;
              else if (total_r == '0) state_nxt = ST_QRD;
              else state_nxt = ST_QMUL;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_NORM: if (y_r[31]) state_nxt = ST_SQ;
      ST_SQ: begin
        mul_a     = y_r;
        mul_b     = y_r;
        state_nxt = ST_SQCHK;
      end
      ST_SQCHK: state_nxt = (bit_r == '0) ? ST_LGMUL : ST_SQ;
      ST_LGMUL: begin
        mul_a     = 32'(lg_r);
        mul_b     = inv_gamma_r;
        state_nxt = ST_KEY;
      end
      ST_KEY: state_nxt = ST_FRD;
      ST_FRD: state_nxt = (idx_r == used_r) ? ST_UPD : ST_FCMP;
      ST_FCMP: state_nxt = (rd_key < key_r) ? ST_FRD : ST_UPD;
      ST_UPD: begin
        if (final_r) begin
          state_nxt = ST_DONE;
        end else if (func_r == FUNC_INSERT) begin
          if (found_r) begin
            wr_en     = 1'b1;
            wr_data   = {key_r, cnt_inc(ent_cnt_r)};
            state_nxt = ST_COLTST;
          end else if (32'(used_r) < DEPTH) begin
            state_nxt = ST_SHRD;
          end else begin
            rd_addr   = used_r - 1'b1;
            state_nxt = ST_FULL;
          end
        end else if (!found_r) begin
          state_nxt = ST_DONE;
        end else if (ent_cnt_r <= cnt_t'(1)) begin
          state_nxt = ST_DSRD;
        end else begin
          wr_en     = 1'b1;
          wr_data   = {key_r, ent_cnt_r - 1'b1};
          state_nxt = ST_DONE;
        end
      end
      ST_SHRD: begin
        if (idx_r == pos_r) begin
          wr_en     = 1'b1;
          wr_data   = {key_r, cnt_t'(1)};
          state_nxt = ST_COLTST;
        end else begin
          rd_addr   = idx_r - 1'b1;
          state_nxt = ST_SHWR;
        end
      end
      ST_SHWR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = rd_data;
        state_nxt = ST_SHRD;
      end
      ST_FULL: begin
        wr_en     = 1'b1;
        wr_addr   = used_r - 1'b1;
        wr_data   = {rd_key, cnt_inc(rd_cnt)};
        state_nxt = ST_COLTST;
      end
      ST_DSRD: begin
        if (32'(idx_r) + 1 >= 32'(used_r)) begin
          state_nxt = ST_DONE;
        end else begin
          rd_addr   = idx_r + 1'b1;
          state_nxt = ST_DSWR;
        end
      end
      ST_DSWR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = rd_data;
        state_nxt = ST_DSRD;
      end
      ST_COLTST: state_nxt = (7'(used_r) > limit) ? ST_COLRD : ST_FRD;
      ST_COLRD: begin
        if (idx_r == used_r) state_nxt = changed_r ? ST_CMPRD : ST_FRD;
        else state_nxt = ST_COLCHK;
      end
      ST_COLCHK: state_nxt = ST_COLRD;
      ST_CMPRD: begin
        if (idx_r == used_r) begin
          wr_en     = 1'b1;
          wr_addr   = w_r;
          wr_data   = {acc_key_r, acc_cnt_r};
          state_nxt = ST_COLTST;
        end else begin
          state_nxt = ST_CMPWR;
        end
      end
      ST_CMPWR: begin
        if (have_acc_r && acc_key_r != nk) begin
          wr_en   = 1'b1;
          wr_addr = w_r;
          wr_data = {acc_key_r, acc_cnt_r};
        end
        state_nxt = ST_CMPRD;
      end
      ST_QMUL: begin
        mul_a     = 32'(tot_m1[31:16]);
        mul_b     = 32'(q_r);
        state_nxt = ST_QMUL2;
      end
      ST_QMUL2: begin
        mul_a     = 32'(tot_m1[15:0]);
        mul_b     = 32'(q_r);
        state_nxt = ST_QT;
      end
      ST_QT: state_nxt = ST_QRD;
      ST_QRD: state_nxt = ST_QACC;
      ST_QACC: begin
        if (!zero_r && qsum <= SUM_BITS'(t_r) && 32'(idx_r) + 1 < 32'(used_r))
          state_nxt = ST_QRD;
        else
          state_nxt = ST_DONE;
      end
      ST_DONE: if (!out_ch.valid || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // shared multiplier with registered product
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_gamma_r  <= 32'd2271520;
      key_offset_r <= '0;
      bin_limit_r  <= 7'd64;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_INV_GAMMA: inv_gamma_r  <= cfg_ch.data;
        REG_OFFSET:    key_offset_r <= cfg_ch.data[10:0];
        REG_BIN_LIMIT: bin_limit_r  <= cfg_ch.data[6:0];
        default: ;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_r       <= '0;
      level_r      <= '0;
      total_r      <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          func_r       <= in_ch.func;
          q_r          <= (in_ch.quantile_q > Q_ONE) ? Q_ONE : in_ch.quantile_q;
          neg_r        <= in_ch.sample[31];
          y_r          <= in_ch.sample[31] ? 32'(-in_ch.sample) : in_ch.sample;
          e_r          <= 5'd31;
          key_r        <= '0;
          idx_r        <= '0;
          final_r      <= 1'b0;
          zero_r       <= (total_r == '0);
          res_status_r <= (in_ch.func == FUNC_QUERY && used_r == '0) ? STAT_EMPTY : STAT_OK;
          res_key_r    <= '0;
          res_cnt_r    <= '0;
        end
        ST_NORM: begin
          if (y_r[31]) begin
            lg_r  <= {e_r, 16'd0};
            bit_r <= 4'd15;
          end else begin
            y_r <= y_r << 1;
            e_r <= e_r - 1'b1;
          end
        end
        ST_SQCHK: begin
          if (sq[32]) begin
            y_r        <= sq[32:1];
            lg_r[bit_r] <= 1'b1;
          end else begin
            y_r <= sq[31:0];
          end
          bit_r <= bit_r - 1'b1;
        end
        ST_KEY: begin
          key_r <= make_key(neg_r, shq[31:0] + 32'(shrem), key_offset_r);
          idx_r <= '0;
        end
        ST_FRD: begin
          if (idx_r == used_r) begin
            pos_r   <= used_r;
            found_r <= 1'b0;
          end
        end
        ST_FCMP: begin
          if (rd_key < key_r) begin
            idx_r <= idx_r + 1'b1;
          end else begin
            pos_r     <= idx_r;
            found_r   <= (rd_key == key_r);
            ent_cnt_r <= rd_cnt;
          end
        end
        ST_UPD: begin
          res_key_r <= plain_key(key_r, key_offset_r);
          if (final_r) begin
            res_cnt_r <= found_r ? ent_cnt_r : '0;
          end else if (func_r == FUNC_INSERT) begin
            if (found_r) total_r <= cnt_inc(total_r);
            idx_r <= used_r;
          end else if (!found_r) begin
            res_status_r <= STAT_NOT_FOUND;
          end else begin
            if (total_r != '0) total_r <= total_r - 1'b1;
            idx_r     <= pos_r;
            res_cnt_r <= (ent_cnt_r <= cnt_t'(1)) ? '0 : ent_cnt_r - 1'b1;
          end
        end
        ST_SHRD: begin
          if (idx_r == pos_r) begin
            used_r  <= used_r + 1'b1;
            total_r <= cnt_inc(total_r);
          end
        end
        ST_SHWR: idx_r <= idx_r - 1'b1;
        ST_FULL: begin
          key_r   <= rd_key;
          total_r <= cnt_inc(total_r);
        end
        ST_DSRD: if (32'(idx_r) + 1 >= 32'(used_r)) used_r <= used_r - 1'b1;
        ST_DSWR: idx_r <= idx_r + 1'b1;
        ST_COLTST: begin
          idx_r     <= '0;
          changed_r <= 1'b0;
          if (7'(used_r) <= limit) final_r <= 1'b1;
        end
        ST_COLRD: begin
          if (idx_r == used_r) begin
            idx_r      <= '0;
            w_r        <= '0;
            have_acc_r <= 1'b0;
            if (!changed_r) final_r <= 1'b1;
          end
        end
        ST_COLCHK: begin
          if (nk != rd_key) changed_r <= 1'b1;
          idx_r <= idx_r + 1'b1;
        end
        ST_CMPRD: begin
          if (idx_r == used_r) begin
            used_r <= w_r + 1'b1;
            if (level_r != LEVEL_MAX) level_r <= level_r + 1'b1;
            key_r  <= halve_key(key_r, key_offset_r);
          end
        end
        ST_CMPWR: begin
          if (have_acc_r && acc_key_r == nk) begin
            acc_cnt_r <= cnt_add(acc_cnt_r, rd_cnt);
          end else begin
            if (have_acc_r) w_r <= w_r + 1'b1;
            acc_key_r  <= nk;
            acc_cnt_r  <= rd_cnt;
            have_acc_r <= 1'b1;
          end
          idx_r <= idx_r + 1'b1;
        end
        ST_QMUL2: t_r <= prod_r[31:0];
        ST_QT: begin
          t_r   <= t_r + 32'(prod_r[63:16]);
          idx_r <= '0;
        end
        ST_QACC: begin
          sum_r     <= qsum;
          res_key_r <= plain_key(rd_key, key_offset_r);
          res_cnt_r <= rd_cnt;
          if (!zero_r && qsum <= SUM_BITS'(t_r) && 32'(idx_r) + 1 < 32'(used_r))
            idx_r <= idx_r + 1'b1;
        end
        ST_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_ch.valid || out_ch.ready)) begin
      out_ch.status         <= res_status_r;
      out_ch.bucket_key     <= res_key_r;
      out_ch.bucket_count   <= res_cnt_r;
      out_ch.collapse_level <= level_r;
      out_ch.buckets_used   <= 7'(used_r);
      out_ch.total_count    <= total_r;
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= DEPTH) else $error("bucket count beyond table depth");
  a_level_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> level_r >= $past(level_r)) else $error("collapse level fell");
  a_state_hot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("sequencer state not one-hot");
  a_out_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r == ST_DONE)) else $error("result without finish");
`endif

endmodule
